[rtl/core/assert_macros.svh]
// Assertion macros used by the checker file of this block.
// Depends on nothing; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/adsr_pkg.sv]
// Shared constants and types of the exponential ADSR envelope.
// No dependencies; used by the interfaces, the top level and the checker.
`timescale 1ns / 1ps

package adsr_pkg;

	// field widths
	localparam int SAMPLE_BITS    = 24;
	localparam int GAIN_FRAC_BITS = 46;
	localparam int GAIN_BITS      = GAIN_FRAC_BITS + 2;
	localparam int LEVEL_BITS     = GAIN_FRAC_BITS + 1;
	localparam int ACTION_BITS    = 2;
	localparam int PHASE_BITS     = 3;

	// digit-serial multiplier geometry
	localparam int DIGIT_BITS    = 12;
	localparam int GAIN_DIGITS   = (GAIN_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
	localparam int SAMPLE_DIGITS = (SAMPLE_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
	localparam int LO_BITS       = GAIN_DIGITS * DIGIT_BITS;
	localparam int SMP_LO_BITS   = SAMPLE_DIGITS * DIGIT_BITS;
	localparam int ACC_BITS      = GAIN_BITS + 1;
	localparam int PROD_BITS     = GAIN_BITS + DIGIT_BITS;
	localparam int SUM_BITS      = PROD_BITS + 1;
	localparam int CNT_BITS      = $clog2(GAIN_DIGITS);
	localparam int GW_BITS       = ACC_BITS + LO_BITS - GAIN_FRAC_BITS;
	localparam int SFULL_BITS    = ACC_BITS + SMP_LO_BITS;
	localparam int Y_BITS        = SAMPLE_BITS + 2;

	localparam logic [GAIN_BITS-1:0] UNITY      = GAIN_BITS'(64'd1 << GAIN_FRAC_BITS);
	localparam logic [ACC_BITS-1:0]  ROUND_HALF = ACC_BITS'(64'd1 << (GAIN_FRAC_BITS - 1));
	localparam logic [LEVEL_BITS-1:0] LEVEL_RESET = LEVEL_BITS'(70);

	// register port
	localparam int APB_DATA_BITS = 64;
	localparam int ADDR_LSB      = 3;
	localparam int REG_IDX_BITS  = 3;
	localparam int ADDR_BITS     = ADDR_LSB + REG_IDX_BITS;

	localparam logic [REG_IDX_BITS-1:0] REG_ATTACK  = 3'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_DECAY   = 3'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_RELEASE = 3'd2;
	localparam logic [REG_IDX_BITS-1:0] REG_SUSTAIN = 3'd3;
	localparam logic [REG_IDX_BITS-1:0] REG_FLOOR   = 3'd4;

	// item actions
	localparam logic [ACTION_BITS-1:0] ACT_SAMPLE   = 2'd0;
	localparam logic [ACTION_BITS-1:0] ACT_NOTE_ON  = 2'd1;
	localparam logic [ACTION_BITS-1:0] ACT_NOTE_OFF = 2'd2;

	// envelope phases
	localparam logic [PHASE_BITS-1:0] PH_OFF     = 3'd0;
	localparam logic [PHASE_BITS-1:0] PH_ATTACK  = 3'd1;
	localparam logic [PHASE_BITS-1:0] PH_DECAY   = 3'd2;
	localparam logic [PHASE_BITS-1:0] PH_SUSTAIN = 3'd3;
	localparam logic [PHASE_BITS-1:0] PH_RELEASE = 3'd4;

	typedef struct packed {
		logic [PHASE_BITS-1:0] phase;
		logic [GAIN_BITS-1:0]  gain;
		logic [GAIN_BITS-1:0]  mult;
	} env_state_t;

endpackage

[rtl/core/adsr_in_if.sv]
// Input item channel: note action and audio sample, valid/ready.
// Depends on adsr_pkg.
`timescale 1ns / 1ps

interface adsr_in_if;
	logic                                   valid;
	logic                                   ready;
	logic [adsr_pkg::ACTION_BITS-1:0]       action;
	logic signed [adsr_pkg::SAMPLE_BITS-1:0] sample_in;

	modport source (output valid, action, sample_in, input ready);
	modport sink (input valid, action, sample_in, output ready);
endinterface

[rtl/core/adsr_out_if.sv]
// Result item channel: scaled sample and envelope phase, valid/ready.
// Depends on adsr_pkg.
`timescale 1ns / 1ps

interface adsr_out_if;
	logic                                    valid;
	logic                                    ready;
	logic signed [adsr_pkg::SAMPLE_BITS-1:0] sample_out;
	logic [adsr_pkg::PHASE_BITS-1:0]         phase_out;

	modport source (output valid, sample_out, phase_out, input ready);
	modport sink (input valid, sample_out, phase_out, output ready);
endinterface

[rtl/core/exponential_adsr_envelope.sv]
// Exponential ADSR envelope: each item may start or stop a note, then the
// gain is multiplied by the per-sample multiplier of the current phase and
// the sample is scaled by the new gain, both rounded and saturated. One item
// is in flight at a time: the single 48x12 digit-serial multiplier forms the
// gain product over four digits, the gain is saturated and stored, and then
// the multiplier forms the sample product over two. The input is taken again
// as soon as the result sits in the output register. Registers sit on an APB
// port at byte address 8*i, 64-bit data. Depends on adsr_pkg, adsr_in_if and
// adsr_out_if.
`timescale 1ns / 1ps

module exponential_adsr_envelope (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [adsr_pkg::ADDR_BITS-1:0]      paddr,
	input  logic [adsr_pkg::APB_DATA_BITS-1:0]  pwdata,
	output logic [adsr_pkg::APB_DATA_BITS-1:0]  prdata,
	output logic                                pready,
	adsr_in_if.sink                             in_ch,
	adsr_out_if.source                          out_ch
);
	import adsr_pkg::*;

	// sequencer codes
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_GMUL = 3'd1;
	localparam logic [2:0] ST_GSAT = 3'd2;
	localparam logic [2:0] ST_SMUL = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0]              state_q;
	logic [CNT_BITS-1:0]     cnt_q;
	logic [GAIN_BITS-1:0]    attack_q, decay_q, release_q;
	logic [LEVEL_BITS-1:0]   sustain_q, floor_q;
	logic [PHASE_BITS-1:0]   phase_q;
	logic [GAIN_BITS-1:0]    env_gain_q, step_mult_q;
	logic                    out_valid_q;

	logic [ACC_BITS-1:0]     acc_q;
	logic [LO_BITS-1:0]      lo_q;
	logic [LO_BITS-1:0]      dig_q;
	logic                    neg_q;
	logic [SAMPLE_BITS-1:0]  mag_q;
	logic [SAMPLE_BITS-1:0]  sample_out_q;
	logic [PHASE_BITS-1:0]   phase_out_q;

	logic                    in_fire, out_free, cfg_wr;
	logic [REG_IDX_BITS-1:0] reg_idx;
	env_state_t              st_cur, st_ev, st_a, st_d, st_r;
	logic [PROD_BITS-1:0]    prod;
	logic [SUM_BITS-1:0]     sum;
	logic [GW_BITS-1:0]      g_wide;
	logic [GAIN_BITS-1:0]    g_sat;
	logic [SFULL_BITS-1:0]   s_full;
	logic [Y_BITS-1:0]       y_raw, y_lim, y_cap;
	logic [SAMPLE_BITS-1:0]  y_out;
	logic [SAMPLE_BITS-1:0]  mag_in;

	// enter a phase, falling through zero-length segments
	function automatic env_state_t enter_phase(
		input logic [PHASE_BITS-1:0] target,
		input env_state_t            cur,
		input logic [GAIN_BITS-1:0]  att,
		input logic [GAIN_BITS-1:0]  dec,
		input logic [GAIN_BITS-1:0]  rel,
		input logic [LEVEL_BITS-1:0] sus,
		input logic [LEVEL_BITS-1:0] flo
	);
		env_state_t            r;
		logic [PHASE_BITS-1:0] p;
		r = cur;
		p = target;
		if (p == PH_ATTACK && att == '0) p = PH_DECAY;
		if (p == PH_DECAY && dec == '0) p = PH_SUSTAIN;
		if (p == PH_RELEASE && rel == '0) p = PH_OFF;
		r.phase = p;
		unique case (p)
			PH_ATTACK: begin
				r.mult = att;
				r.gain = GAIN_BITS'(flo);
			end
			PH_DECAY: begin
				r.gain = UNITY;
				r.mult = dec;
			end
			PH_SUSTAIN: begin
				r.gain = GAIN_BITS'(sus);
				r.mult = UNITY;
			end
			PH_RELEASE: begin
				r.mult = rel;
			end
			default: begin
				r.gain = '0;
			end
		endcase
		return r;
	endfunction

	assign in_fire  = in_ch.valid && in_ch.ready;
	assign out_free = !out_valid_q || out_ch.ready;
	assign in_ch.ready = (state_q == ST_IDLE);

	// register port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = paddr[ADDR_BITS-1:ADDR_LSB];

	always_comb begin
		unique case (reg_idx)
			REG_ATTACK:  prdata = APB_DATA_BITS'(attack_q);
			REG_DECAY:   prdata = APB_DATA_BITS'(decay_q);
			REG_RELEASE: prdata = APB_DATA_BITS'(release_q);
			REG_SUSTAIN: prdata = APB_DATA_BITS'(sustain_q);
			REG_FLOOR:   prdata = APB_DATA_BITS'(floor_q);
			default:     prdata = '0;
		endcase
	end

	// note event, then the chained phase checks
	always_comb begin
		st_cur = '{phase: phase_q, gain: env_gain_q, mult: step_mult_q};
		st_ev  = st_cur;
		if (in_ch.action == ACT_NOTE_ON)
			st_ev = enter_phase(PH_ATTACK, st_cur, attack_q, decay_q, release_q,
				sustain_q, floor_q);
		else if (in_ch.action == ACT_NOTE_OFF)
			st_ev = enter_phase(PH_RELEASE, st_cur, attack_q, decay_q, release_q,
				sustain_q, floor_q);
		st_a = st_ev;
		if (st_ev.phase == PH_ATTACK && st_ev.gain >= UNITY)
			st_a = enter_phase(PH_DECAY, st_ev, attack_q, decay_q, release_q,
				sustain_q, floor_q);
		st_d = st_a;
		if (st_a.phase == PH_DECAY && st_a.gain < GAIN_BITS'(sustain_q))
			st_d = enter_phase(PH_SUSTAIN, st_a, attack_q, decay_q, release_q,
				sustain_q, floor_q);
		st_r = st_d;
		if (st_d.phase == PH_RELEASE && st_d.gain < GAIN_BITS'(floor_q))
			st_r = enter_phase(PH_OFF, st_d, attack_q, decay_q, release_q,
				sustain_q, floor_q);
	end

	// sample magnitude
	assign mag_in = in_ch.sample_in[SAMPLE_BITS-1] ? SAMPLE_BITS'(-in_ch.sample_in)
		: SAMPLE_BITS'(in_ch.sample_in);

	// one digit per cycle: gain times the low digit, added to the carry-over
	assign prod = PROD_BITS'(env_gain_q * dig_q[DIGIT_BITS-1:0]);
	assign sum  = SUM_BITS'(acc_q) + SUM_BITS'(prod);

	// gain product, already rounded, shifted down and saturated
	assign g_wide = GW_BITS'({acc_q, lo_q} >> GAIN_FRAC_BITS);
	assign g_sat  = (|g_wide[GW_BITS-1:GAIN_BITS]) ? '1 : g_wide[GAIN_BITS-1:0];

	// sample product, rounded, clamped to the signed range
	assign s_full = {acc_q, lo_q[LO_BITS-1 -: SMP_LO_BITS]};
	assign y_raw  = s_full[GAIN_FRAC_BITS +: Y_BITS];
	assign y_lim  = neg_q ? Y_BITS'(64'd1 << (SAMPLE_BITS - 1))
		: Y_BITS'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
	assign y_cap  = (y_raw > y_lim) ? y_lim : y_raw;
	assign y_out  = neg_q ? SAMPLE_BITS'(-y_cap[SAMPLE_BITS-1:0]) : y_cap[SAMPLE_BITS-1:0];

	// control, envelope state and registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			attack_q    <= '0;
			decay_q     <= '0;
			release_q   <= '0;
			sustain_q   <= LEVEL_RESET;
			floor_q     <= LEVEL_RESET;
			phase_q     <= PH_OFF;
			env_gain_q  <= '0;
			step_mult_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				unique case (reg_idx)
					REG_ATTACK:  attack_q  <= pwdata[GAIN_BITS-1:0];
					REG_DECAY:   decay_q   <= pwdata[GAIN_BITS-1:0];
					REG_RELEASE: release_q <= pwdata[GAIN_BITS-1:0];
					REG_SUSTAIN: sustain_q <= pwdata[LEVEL_BITS-1:0];
					REG_FLOOR:   floor_q   <= pwdata[LEVEL_BITS-1:0];
					default: ;
				endcase
			end
			// result valid: set when a result lands, cleared when taken
			if (state_q == ST_OUT && out_free)
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						phase_q     <= st_r.phase;
						env_gain_q  <= st_r.gain;
						step_mult_q <= st_r.mult;
						cnt_q       <= '0;
						state_q     <= ST_GMUL;
					end
				end
				ST_GMUL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_BITS'(GAIN_DIGITS - 1))
						state_q <= ST_GSAT;
				end
				ST_GSAT: begin
					env_gain_q <= g_sat;
					cnt_q      <= '0;
					state_q    <= ST_SMUL;
				end
				ST_SMUL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_BITS'(SAMPLE_DIGITS - 1))
						state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// multiplier datapath and result register
	always_ff @(posedge clk) begin
		unique case (state_q) inside
			ST_IDLE: begin
				if (in_fire) begin
					dig_q <= st_r.mult;
					acc_q <= ROUND_HALF;
					neg_q <= in_ch.sample_in[SAMPLE_BITS-1];
					mag_q <= mag_in;
				end
			end
			ST_GMUL, ST_SMUL: begin
				acc_q <= sum[SUM_BITS-1:DIGIT_BITS];
				lo_q  <= {sum[DIGIT_BITS-1:0], lo_q[LO_BITS-1:DIGIT_BITS]};
				dig_q <= dig_q >> DIGIT_BITS;
			end
			ST_GSAT: begin
				dig_q <= LO_BITS'(mag_q);
				acc_q <= ROUND_HALF;
			end
			ST_OUT: begin
				if (out_free) begin
					sample_out_q <= y_out;
					phase_out_q  <= phase_q;
				end
			end
			default: ;
		endcase
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.sample_out = sample_out_q;
	assign out_ch.phase_out  = phase_out_q;

endmodule

[rtl/core/adsr_checker.sv]
// Port-level checks of the exponential ADSR envelope, bound to the top level.
// Depends on adsr_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module adsr_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [adsr_pkg::SAMPLE_BITS-1:0]  sample_out,
	input logic [adsr_pkg::PHASE_BITS-1:0]   phase_out
);
	import adsr_pkg::*;

	// one item in flight: no second item right after one is taken
	`ASSERT_NEXT(a_one_in_flight, clk, arst_n, in_valid && in_ready, !in_ready, "item taken while busy")

	// a fresh item never produces its result in the next cycle
	`ASSERT_NEXT(a_min_latency, clk, arst_n, in_valid && in_ready && !out_valid, !out_valid, "result too early")

	// the off phase carries zero gain
	`ASSERT_IMPL(a_off_silent, clk, arst_n, out_valid && phase_out == PH_OFF, sample_out == '0, "sound while off")

	// a stalled result holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(sample_out) && $stable(phase_out), "stalled item changed")

endmodule

bind exponential_adsr_envelope adsr_checker u_adsr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.sample_out (out_ch.sample_out),
	.phase_out  (out_ch.phase_out)
);

[verif/exponential_adsr_envelope_tb.sv]
// Self-checking testbench for the exponential ADSR envelope: random note
// sequences against a cycle-free envelope predictor, checked item by item.
// Depends on adsr_pkg, adsr_in_if, adsr_out_if and exponential_adsr_envelope.
`timescale 1ns / 1ps

module exponential_adsr_envelope_tb;
	import adsr_pkg::*;

	localparam int STALL_LIMIT     = 5000;
	localparam int DRAIN_CYCLES    = 20;
	localparam int RANDOM_PHASES   = 9;
	localparam int ITEMS_PER_PHASE = 137;
	localparam int MAX_REPORTS     = 10;
	localparam int IDLE_PCT        = 14;
	localparam int STEADY_PHASE    = 4;

	// codes the block has no use for
	localparam logic [ACTION_BITS-1:0]  ACT_SPARE    = 2'd3;
	localparam logic [REG_IDX_BITS-1:0] REG_SPARE_LO = 3'd5;
	localparam logic [REG_IDX_BITS-1:0] REG_SPARE_HI = 3'd7;

	localparam logic [GAIN_BITS-1:0]         GAIN_MAX  = '1;
	localparam logic [LEVEL_BITS-1:0]        LEVEL_MAX = '1;
	localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX  = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	typedef struct {
		logic [ACTION_BITS-1:0]        action;
		logic signed [SAMPLE_BITS-1:0] sample;
		bit                            hold;
	} note_item_t;

	typedef struct {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic [PHASE_BITS-1:0]         phase;
	} env_out_t;

	logic                     clk;
	logic                     arst_n;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [ADDR_BITS-1:0]     paddr;
	logic [APB_DATA_BITS-1:0] pwdata;
	logic [APB_DATA_BITS-1:0] prdata;
	logic                     pready;

	adsr_in_if  in_ch();
	adsr_out_if out_ch();

	exponential_adsr_envelope uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.in_ch   (in_ch),
		.out_ch  (out_ch)
	);

	// register shadow copies
	logic [GAIN_BITS-1:0]  cfg_attack, cfg_decay, cfg_release;
	logic [LEVEL_BITS-1:0] cfg_sustain, cfg_floor;

	// predicted envelope state
	logic [PHASE_BITS-1:0] env_phase;
	logic [GAIN_BITS-1:0]  env_gain;
	logic [GAIN_BITS-1:0]  env_mult;

	note_item_t  pending_notes[$];
	env_out_t    expected_out[$];
	note_item_t  shown_note;
	int unsigned sent_cnt;
	int unsigned taken_cnt;
	int          mismatch_cnt;
	bit          steady;

	// 2 ns clock
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Q2.46 product, rounded half up, not yet saturated
	function automatic logic [127:0] q46_mul(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = 128'(a) * 128'(b) + (128'(1) << (GAIN_FRAC_BITS - 1));
		return p >> GAIN_FRAC_BITS;
	endfunction

	function automatic void note_mismatch(input string what, input int want, input int got);
		mismatch_cnt++;
		if (mismatch_cnt <= MAX_REPORTS)
			$display("%0t ns: %s: expected %0d, got %0d", $time, what, want, got);
	endfunction

	// zero-length segments fall through to the next phase
	task automatic enter_env_phase(input logic [PHASE_BITS-1:0] target);
		logic [PHASE_BITS-1:0] p;
		p = target;
		if (p == PH_ATTACK && cfg_attack == '0)
			p = PH_DECAY;
		if (p == PH_DECAY && cfg_decay == '0)
			p = PH_SUSTAIN;
		if (p == PH_RELEASE && cfg_release == '0)
			p = PH_OFF;
		env_phase = p;
		case (p)
			PH_ATTACK: begin
				env_mult = cfg_attack;
				env_gain = GAIN_BITS'(cfg_floor);
			end
			PH_DECAY: begin
				env_gain = UNITY;
				env_mult = cfg_decay;
			end
			PH_SUSTAIN: begin
				env_gain = GAIN_BITS'(cfg_sustain);
				env_mult = UNITY;
			end
			PH_RELEASE: begin
				env_mult = cfg_release;
			end
			default: begin
				env_gain = '0;
			end
		endcase
	endtask

	// one accepted item: event, phase checks, gain step, sample scaling
	task automatic predict_note(input note_item_t it);
		logic [127:0]           g;
		logic [127:0]           y;
		logic                   neg;
		logic [SAMPLE_BITS-1:0] mag;
		logic [SAMPLE_BITS-1:0] lim;
		env_out_t               r;
		if (it.action == ACT_NOTE_ON)
			enter_env_phase(PH_ATTACK);
		else if (it.action == ACT_NOTE_OFF)
			enter_env_phase(PH_RELEASE);

		if (env_phase == PH_ATTACK && env_gain >= UNITY)
			enter_env_phase(PH_DECAY);
		if (env_phase == PH_DECAY && env_gain < GAIN_BITS'(cfg_sustain))
			enter_env_phase(PH_SUSTAIN);
		if (env_phase == PH_RELEASE && env_gain < GAIN_BITS'(cfg_floor))
			enter_env_phase(PH_OFF);

		g = q46_mul(64'(env_gain), 64'(env_mult));
		env_gain = (g > 128'(GAIN_MAX)) ? GAIN_MAX : g[GAIN_BITS-1:0];

		neg = it.sample[SAMPLE_BITS-1];
		mag = neg ? (~it.sample + 1'b1) : it.sample;
		lim = neg ? SMP_MIN : SMP_MAX;
		y = q46_mul(64'(mag), 64'(env_gain));
		if (y > 128'(lim))
			y = 128'(lim);
		r.sample = neg ? (~y[SAMPLE_BITS-1:0] + 1'b1) : y[SAMPLE_BITS-1:0];
		r.phase = env_phase;
		expected_out.push_back(r);
	endtask

	// APB write; bits above the field are filled with junk to exercise masking
	task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx, input logic [63:0] value);
		logic [63:0] field;
		logic [63:0] junk;
		junk = rand64();
		field = (idx == REG_SUSTAIN || idx == REG_FLOOR) ? 64'(LEVEL_MAX) : 64'(GAIN_MAX);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, {ADDR_LSB{1'b0}}};
		pwdata <= (value & field) | (junk & ~field);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_ATTACK:  cfg_attack = value[GAIN_BITS-1:0];
			REG_DECAY:   cfg_decay = value[GAIN_BITS-1:0];
			REG_RELEASE: cfg_release = value[GAIN_BITS-1:0];
			REG_SUSTAIN: cfg_sustain = value[LEVEL_BITS-1:0];
			REG_FLOOR:   cfg_floor = value[LEVEL_BITS-1:0];
			default:     ;
		endcase
	endtask

	// full register set, plus a write to an unmapped index that must be ignored
	task automatic write_envelope_regs(input logic [63:0] a, input logic [63:0] d,
			input logic [63:0] r, input logic [63:0] s, input logic [63:0] f);
		write_reg(REG_ATTACK, a);
		write_reg(REG_DECAY, d);
		write_reg(REG_RELEASE, r);
		write_reg(REG_SUSTAIN, s);
		write_reg(REG_FLOOR, f);
		write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, rand64());
	endtask

	// setting 0 is all zero, 1 all maximum, 2 forces a zero floor
	task automatic random_setting(input int k);
		logic [63:0] a, d, r, s, f;
		case (k)
			0: begin
				a = '0;
				d = '0;
				r = '0;
				s = '0;
				f = '0;
			end
			1: begin
				a = 64'(GAIN_MAX);
				d = 64'(GAIN_MAX);
				r = 64'(GAIN_MAX);
				s = 64'(LEVEL_MAX);
				f = 64'(LEVEL_MAX);
			end
			default: begin
				case ($urandom_range(0, 9))
					0: a = '0;
					1: a = 64'(GAIN_MAX);
					2: a = 64'(UNITY);
					default: a = 64'(UNITY) + (rand64() >> $urandom_range(17, 22));
				endcase
				case ($urandom_range(0, 9))
					0: d = '0;
					1: d = 64'(GAIN_MAX);
					2: d = 64'(UNITY);
					default: d = 64'(UNITY) - (rand64() >> $urandom_range(19, 24));
				endcase
				case ($urandom_range(0, 9))
					0: r = '0;
					1: r = 64'd1;
					2: r = 64'(GAIN_MAX);
					default: r = 64'(UNITY) - (rand64() >> $urandom_range(18, 22));
				endcase
				case ($urandom_range(0, 9))
					0: s = '0;
					1: s = 64'(UNITY);
					2: s = 64'(LEVEL_MAX);
					default: s = rand64() >> $urandom_range(18, 22);
				endcase
				case ($urandom_range(0, 9))
					0: f = '0;
					1: f = 64'(LEVEL_RESET);
					2: f = 64'(UNITY);
					default: f = rand64() >> $urandom_range(19, 34);
				endcase
				if (k == 2)
					f = '0;
			end
		endcase
		write_envelope_regs(a, d, r, s, f);
	endtask

	function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
		case ($urandom_range(0, 19))
			0: return SMP_MAX;
			1: return SMP_MIN;
			2: return '0;
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	task automatic queue_note(input logic [ACTION_BITS-1:0] act,
			input logic signed [SAMPLE_BITS-1:0] smp);
		note_item_t it;
		it.action = act;
		it.sample = smp;
		it.hold = ($urandom_range(0, 99) == 0);
		pending_notes.push_back(it);
	endtask

	// mostly note-on / hold / note-off / tail runs, some stray actions
	task automatic queue_note_sequences(input int count);
		int n;
		int len;
		n = 0;
		while (n < count) begin
			if ($urandom_range(0, 99) < 80) begin
				queue_note(ACT_NOTE_ON, rand_sample());
				len = $urandom_range(0, 40);
				repeat (len) queue_note(ACT_SAMPLE, rand_sample());
				queue_note(ACT_NOTE_OFF, rand_sample());
				n += len + 2;
				len = $urandom_range(0, 30);
				repeat (len) queue_note(ACT_SAMPLE, rand_sample());
				n += len;
			end else begin
				queue_note(ACTION_BITS'($urandom_range(0, 3)), rand_sample());
				n++;
			end
		end
	endtask

	// wait until every item went through and every result came back
	task automatic wait_drained();
		do @(negedge clk);
		while (pending_notes.size() != 0 || in_ch.valid || sent_cnt != taken_cnt);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// input driver
	always @(posedge clk) begin
		bit busy;
		busy = (sent_cnt + (in_ch.valid && in_ch.ready))
			!= (taken_cnt + (out_ch.valid && out_ch.ready));
		if (in_ch.valid && in_ch.ready) begin
			predict_note(shown_note);
			sent_cnt <= sent_cnt + 1;
		end
		if (!in_ch.valid || in_ch.ready) begin
			if (pending_notes.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)
					&& !(pending_notes[0].hold && busy)) begin
				shown_note = pending_notes.pop_front();
				in_ch.valid <= 1'b1;
				in_ch.action <= shown_note.action;
				in_ch.sample_in <= shown_note.sample;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// output monitor
	always @(posedge clk) begin
		env_out_t want;
		if (out_ch.valid && out_ch.ready) begin
			taken_cnt <= taken_cnt + 1;
			if (expected_out.size() == 0) begin
				note_mismatch("result with nothing expected", 0, out_ch.sample_out);
			end else begin
				want = expected_out.pop_front();
				if (out_ch.sample_out !== want.sample)
					note_mismatch("sample_out", want.sample, out_ch.sample_out);
				if (out_ch.phase_out !== want.phase)
					note_mismatch("phase_out", want.phase, out_ch.phase_out);
			end
		end
		out_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// watchdog on cycles with no handshake at all
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
					|| (psel && penable && pwrite && pready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Mismatches found");
		$finish;
	end

	// stimulus sequence
	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.action = ACT_SAMPLE;
		in_ch.sample_in = '0;
		out_ch.ready = 1'b0;
		steady = 1'b0;
		sent_cnt = 0;
		taken_cnt = 0;
		mismatch_cnt = 0;
		cfg_attack = '0;
		cfg_decay = '0;
		cfg_release = '0;
		cfg_sustain = LEVEL_RESET;
		cfg_floor = LEVEL_RESET;
		env_phase = PH_OFF;
		env_gain = '0;
		env_mult = '0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// reset values: every segment is zero length
		queue_note(ACT_SAMPLE, SMP_MAX);
		queue_note(ACT_NOTE_ON, SMP_MAX);
		queue_note(ACT_SPARE, SMP_MIN);
		queue_note(ACT_NOTE_OFF, SMP_MIN);
		wait_drained();

		// doubling attack from 2^-6, gentle decay to a quarter, halving release
		write_envelope_regs(64'(UNITY) << 1, 64'(UNITY) - (64'(UNITY) >> 3),
			64'(UNITY) >> 1, 64'(UNITY) >> 2, 64'd1 << 40);
		queue_note(ACT_NOTE_OFF, 24'sd12345);      // note-off while off
		queue_note(ACT_NOTE_ON, SMP_MAX);
		queue_note(ACT_SAMPLE, SMP_MIN);
		queue_note(ACT_SAMPLE, SMP_MAX);
		queue_note(ACT_SAMPLE, '0);
		queue_note(ACT_SAMPLE, -24'sd1);
		queue_note(ACT_SAMPLE, 24'sd1);
		repeat (3) queue_note(ACT_SAMPLE, SMP_MAX);
		queue_note(ACT_NOTE_ON, SMP_MAX);          // retrigger in decay
		queue_note(ACT_SAMPLE, SMP_MIN);
		queue_note(ACT_NOTE_OFF, SMP_MAX);
		queue_note(ACT_SAMPLE, SMP_MAX);
		queue_note(ACT_SAMPLE, SMP_MIN);
		wait_drained();

		// levels above unity and saturating gain
		write_envelope_regs(64'(GAIN_MAX), 64'(GAIN_MAX), 64'(GAIN_MAX),
			64'(LEVEL_MAX), 64'(LEVEL_MAX));
		queue_note(ACT_NOTE_ON, SMP_MAX);
		queue_note(ACT_SAMPLE, SMP_MIN);
		queue_note(ACT_NOTE_OFF, SMP_MAX);
		queue_note(ACT_SAMPLE, 24'sd1);
		wait_drained();

		// random settings, one with no idling on either side
		for (int k = 0; k < RANDOM_PHASES; k++) begin
			steady <= (k == STEADY_PHASE);
			random_setting(k);
			queue_note_sequences(ITEMS_PER_PHASE);
			wait_drained();
		end

		if (mismatch_cnt == 0 && expected_out.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
